### src/ppc_pkg.sv
package ppc_pkg;

    typedef logic [2:0] t_cmd;

    localparam t_cmd CMD_COMPOUND_POSE  = 3'd0;
    localparam t_cmd CMD_COMPOUND_POINT = 3'd1;
    localparam t_cmd CMD_RELATIVE_POSE  = 3'd2;
    localparam t_cmd CMD_RELATIVE_POINT = 3'd3;
    localparam t_cmd CMD_INVERSE        = 3'd4;

    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_GUARD = 6;
    localparam int X_GROWTH     = 10;
    localparam int Z_WIDTH      = 34;
    localparam int GAIN_WIDTH   = 30;

    localparam logic [GAIN_WIDTH-1:0] INV_GAIN_Q30 = 30'd652032874;

    function automatic logic [31:0] atan_at(input int step);
        logic [31:0] v;
        unique case (step)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10680862;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

### src/ppc_prep.sv
module ppc_prep #(
    parameter int CW = 32,
    parameter int AW = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  ppc_pkg::t_cmd                         i_command,
    input  logic signed [CW-1:0]                  i_base_x,
    input  logic signed [CW-1:0]                  i_base_y,
    input  logic [AW-1:0]                         i_base_heading,
    input  logic signed [CW-1:0]                  i_other_x,
    input  logic signed [CW-1:0]                  i_other_y,
    input  logic [AW-1:0]                         i_other_heading,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [CW+ppc_pkg::X_GROWTH-1:0] o_x,
    output logic signed [CW+ppc_pkg::X_GROWTH-1:0] o_y,
    output logic signed [ppc_pkg::Z_WIDTH-1:0]     o_z,
    output logic [2*CW+AW:0]                      o_side
);

    localparam int XW = CW + ppc_pkg::X_GROWTH;
    localparam int ZW = ppc_pkg::Z_WIDTH;
    localparam int UW = CW + 1;
    localparam int SW = 2 * CW + AW + 1;

    logic signed [UW-1:0] w_px, w_mx, w_py, w_my, w_ux, w_uy;
    logic [AW-1:0]        w_ang, w_ang_adj, w_hd, w_neg_bh;
    logic                 w_add_base, w_flip;
    logic signed [XW-1:0] n_x, n_y;
    logic signed [ZW-1:0] n_z;
    logic [SW-1:0]        n_side;

    logic                 r_valid;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [SW-1:0]        r_side;

    always_comb begin
        w_neg_bh   = AW'(0) - i_base_heading;
        w_px       = '0;
        w_mx       = '0;
        w_py       = '0;
        w_my       = '0;
        w_ang      = '0;
        w_hd       = '0;
        w_add_base = 1'b0;
        unique case (i_command)
            ppc_pkg::CMD_COMPOUND_POSE, ppc_pkg::CMD_COMPOUND_POINT: begin
                w_px       = UW'(i_other_x);
                w_py       = UW'(i_other_y);
                w_ang      = i_base_heading;
                w_add_base = 1'b1;
                if (i_command == ppc_pkg::CMD_COMPOUND_POSE) begin
                    w_hd = i_base_heading + i_other_heading;
                end
            end
            ppc_pkg::CMD_RELATIVE_POSE, ppc_pkg::CMD_RELATIVE_POINT: begin
                w_px  = UW'(i_other_x);
                w_py  = UW'(i_other_y);
                w_mx  = UW'(i_base_x);
                w_my  = UW'(i_base_y);
                w_ang = w_neg_bh;
                if (i_command == ppc_pkg::CMD_RELATIVE_POSE) begin
                    w_hd = i_other_heading - i_base_heading;
                end
            end
            ppc_pkg::CMD_INVERSE: begin
                w_mx  = UW'(i_base_x);
                w_my  = UW'(i_base_y);
                w_ang = w_neg_bh;
                w_hd  = w_neg_bh;
            end
            default: begin
                w_px = '0;
            end
        endcase

        // Headings in the second and third quadrant are folded by a half turn.
        w_flip    = w_ang[AW-1] ^ w_ang[AW-2];
        w_ux      = w_flip ? (w_mx - w_px) : (w_px - w_mx);
        w_uy      = w_flip ? (w_my - w_py) : (w_py - w_my);
        w_ang_adj = {w_ang[AW-1] ^ w_flip, w_ang[AW-2:0]};

        n_z    = ZW'($signed(w_ang_adj)) <<< (32 - AW);
        n_x    = XW'(w_ux) <<< ppc_pkg::CORDIC_GUARD;
        n_y    = XW'(w_uy) <<< ppc_pkg::CORDIC_GUARD;
        n_side = {w_add_base, i_base_x, i_base_y, w_hd};
    end

    assign o_ready = ~r_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

### src/ppc_cordic_cell.sv
module ppc_cordic_cell #(
    parameter int CW   = 32,
    parameter int AW   = 16,
    parameter int STEP = 0
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [CW+ppc_pkg::X_GROWTH-1:0] i_x,
    input  logic signed [CW+ppc_pkg::X_GROWTH-1:0] i_y,
    input  logic signed [ppc_pkg::Z_WIDTH-1:0]     i_z,
    input  logic [2*CW+AW:0]                      i_side,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [CW+ppc_pkg::X_GROWTH-1:0] o_x,
    output logic signed [CW+ppc_pkg::X_GROWTH-1:0] o_y,
    output logic signed [ppc_pkg::Z_WIDTH-1:0]     o_z,
    output logic [2*CW+AW:0]                      o_side
);

    localparam int XW = CW + ppc_pkg::X_GROWTH;
    localparam int ZW = ppc_pkg::Z_WIDTH;
    localparam int SW = 2 * CW + AW + 1;
    localparam logic signed [ZW-1:0] ATAN = ZW'(ppc_pkg::atan_at(STEP));

    logic signed [XW-1:0] w_dx, w_dy, n_x, n_y;
    logic signed [ZW-1:0] n_z;

    logic                 r_valid;
    logic signed [XW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [SW-1:0]        r_side;

    always_comb begin
        w_dx = i_y >>> STEP;
        w_dy = i_x >>> STEP;
        if (!i_z[ZW-1]) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + ATAN;
        end
    end

    assign o_ready = ~r_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

### src/ppc_finish.sv
module ppc_finish #(
    parameter int CW = 32,
    parameter int AW = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [CW+ppc_pkg::X_GROWTH-1:0] i_x,
    input  logic signed [CW+ppc_pkg::X_GROWTH-1:0] i_y,
    input  logic [2*CW+AW:0]                      i_side,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [CW-1:0]                  o_x,
    output logic signed [CW-1:0]                  o_y,
    output logic [AW-1:0]                         o_heading,
    output logic                                  o_saturated
);

    localparam int XW = CW + ppc_pkg::X_GROWTH;
    localparam int SW = 2 * CW + AW + 1;
    localparam int GW = ppc_pkg::GAIN_WIDTH;
    localparam int MW = XW - 1;
    localparam int LW = (MW + 1) / 2;
    localparam int HW = MW - LW;
    localparam int PW = MW + GW + 1;
    localparam int RW = PW - 36;
    localparam int VW = CW + 6;
    localparam int NS = 5;

    localparam logic [PW-1:0] ROUND = {{(PW-36){1'b0}}, 1'b1, 35'd0};
    localparam logic signed [VW-1:0] HI_V = {{(VW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [VW-1:0] LO_V = ~HI_V;

    logic [NS-1:0] r_v;
    logic [NS:0]   w_rdy;

    logic [MW-1:0]        n_mx, n_my;
    logic [LW+GW-1:0]     n_plx, n_ply;
    logic [HW+GW-1:0]     n_phx, n_phy;
    logic [PW-1:0]        n_sumx, n_sumy;
    logic signed [VW-1:0] w_ax, w_ay, n_vx, n_vy;
    logic signed [CW-1:0] n_ox, n_oy;
    logic                 n_satx, n_saty;

    logic [MW-1:0]        r_mx, r_my;
    logic                 r_nx1, r_ny1, r_nx2, r_ny2, r_nx3, r_ny3;
    logic [SW-1:0]        r_s1, r_s2, r_s3;
    logic [LW+GW-1:0]     r_plx, r_ply;
    logic [HW+GW-1:0]     r_phx, r_phy;
    logic [RW-1:0]        r_rx, r_ry;
    logic signed [VW-1:0] r_vx, r_vy;
    logic [AW-1:0]        r_h4, r_oh;
    logic signed [CW-1:0] r_ox, r_oy;
    logic                 r_sat;

    always_comb begin
        w_rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = ~r_v[k] | w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];

    always_comb begin
        n_mx = MW'(i_x[XW-1] ? -i_x : i_x);
        n_my = MW'(i_y[XW-1] ? -i_y : i_y);

        n_plx = {{GW{1'b0}}, r_mx[LW-1:0]} * {{LW{1'b0}}, ppc_pkg::INV_GAIN_Q30};
        n_phx = {{GW{1'b0}}, r_mx[MW-1:LW]} * {{HW{1'b0}}, ppc_pkg::INV_GAIN_Q30};
        n_ply = {{GW{1'b0}}, r_my[LW-1:0]} * {{LW{1'b0}}, ppc_pkg::INV_GAIN_Q30};
        n_phy = {{GW{1'b0}}, r_my[MW-1:LW]} * {{HW{1'b0}}, ppc_pkg::INV_GAIN_Q30};

        // Rounding to nearest on the magnitude gives ties away from zero.
        n_sumx = (PW'(r_phx) << LW) + PW'(r_plx) + ROUND;
        n_sumy = (PW'(r_phy) << LW) + PW'(r_ply) + ROUND;

        w_ax = r_s3[SW-1] ? VW'($signed(r_s3[SW-2 -: CW])) : '0;
        w_ay = r_s3[SW-1] ? VW'($signed(r_s3[AW+CW-1 -: CW])) : '0;
        n_vx = r_nx3 ? (w_ax - VW'($signed({1'b0, r_rx})))
                     : (w_ax + VW'($signed({1'b0, r_rx})));
        n_vy = r_ny3 ? (w_ay - VW'($signed({1'b0, r_ry})))
                     : (w_ay + VW'($signed({1'b0, r_ry})));

        n_satx = (r_vx > HI_V) || (r_vx < LO_V);
        n_saty = (r_vy > HI_V) || (r_vy < LO_V);
        if (r_vx > HI_V) begin
            n_ox = CW'(HI_V);
        end else if (r_vx < LO_V) begin
            n_ox = CW'(LO_V);
        end else begin
            n_ox = CW'(r_vx);
        end
        if (r_vy > HI_V) begin
            n_oy = CW'(HI_V);
        end else if (r_vy < LO_V) begin
            n_oy = CW'(LO_V);
        end else begin
            n_oy = CW'(r_vy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end

        if (w_rdy[0] && i_valid) begin
            r_mx  <= n_mx;
            r_my  <= n_my;
            r_nx1 <= i_x[XW-1];
            r_ny1 <= i_y[XW-1];
            r_s1  <= i_side;
        end
        if (w_rdy[1] && r_v[0]) begin
            r_plx <= n_plx;
            r_phx <= n_phx;
            r_ply <= n_ply;
            r_phy <= n_phy;
            r_nx2 <= r_nx1;
            r_ny2 <= r_ny1;
            r_s2  <= r_s1;
        end
        if (w_rdy[2] && r_v[1]) begin
            r_rx  <= n_sumx[PW-1:36];
            r_ry  <= n_sumy[PW-1:36];
            r_nx3 <= r_nx2;
            r_ny3 <= r_ny2;
            r_s3  <= r_s2;
        end
        if (w_rdy[3] && r_v[2]) begin
            r_vx <= n_vx;
            r_vy <= n_vy;
            r_h4 <= r_s3[AW-1:0];
        end
        if (w_rdy[4] && r_v[3]) begin
            r_ox  <= n_ox;
            r_oy  <= n_oy;
            r_oh  <= r_h4;
            r_sat <= n_satx | n_saty;
        end
    end

    assign o_valid     = r_v[NS-1];
    assign o_x         = r_ox;
    assign o_y         = r_oy;
    assign o_heading   = r_oh;
    assign o_saturated = r_sat;

endmodule

### src/planar_pose_compose.sv
// Composes, relates and inverts planar poses in Q16.16 with binary-angle headings, one
// beat per clock cycle when the output side keeps up. Each beat passes one input register
// stage, a row of 28 CORDIC cells (one micro-rotation per cell), and five stages for gain
// compensation, sign, translation and saturation. Every stage holds its beat while the next
// one is full, so idle stages keep accepting while a finished result waits at the output.
module planar_pose_compose #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  ppc_pkg::t_cmd                i_command,
    input  logic signed [COORD_WIDTH-1:0] i_base_x,
    input  logic signed [COORD_WIDTH-1:0] i_base_y,
    input  logic [ANGLE_WIDTH-1:0]       i_base_heading,
    input  logic signed [COORD_WIDTH-1:0] i_other_x,
    input  logic signed [COORD_WIDTH-1:0] i_other_y,
    input  logic [ANGLE_WIDTH-1:0]       i_other_heading,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic [ANGLE_WIDTH-1:0]       o_out_heading,
    output logic                         o_saturated
);

    localparam int CW = COORD_WIDTH;
    localparam int AW = ANGLE_WIDTH;
    localparam int XW = CW + ppc_pkg::X_GROWTH;
    localparam int ZW = ppc_pkg::Z_WIDTH;
    localparam int SW = 2 * CW + AW + 1;
    localparam int NC = ppc_pkg::CORDIC_STEPS;

    localparam logic signed [CW-1:0] MAX_C = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MIN_C = {1'b1, {(CW-1){1'b0}}};

    logic                 w_v   [0:NC];
    logic                 w_rdy [0:NC];
    logic signed [XW-1:0] w_x   [0:NC];
    logic signed [XW-1:0] w_y   [0:NC];
    logic signed [ZW-1:0] w_z   [0:NC];
    logic [SW-1:0]        w_s   [0:NC];

    ppc_prep #(
        .CW(CW),
        .AW(AW)
    ) u_prep (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_ready         (o_in_ready),
        .i_command       (i_command),
        .i_base_x        (i_base_x),
        .i_base_y        (i_base_y),
        .i_base_heading  (i_base_heading),
        .i_other_x       (i_other_x),
        .i_other_y       (i_other_y),
        .i_other_heading (i_other_heading),
        .o_valid         (w_v[0]),
        .i_ready         (w_rdy[0]),
        .o_x             (w_x[0]),
        .o_y             (w_y[0]),
        .o_z             (w_z[0]),
        .o_side          (w_s[0])
    );

    for (genvar g = 0; g < NC; g++) begin : g_cell
        ppc_cordic_cell #(
            .CW   (CW),
            .AW   (AW),
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[g]),
            .o_ready (w_rdy[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .i_side  (w_s[g]),
            .o_valid (w_v[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1]),
            .o_side  (w_s[g+1])
        );
    end

    ppc_finish #(
        .CW(CW),
        .AW(AW)
    ) u_finish (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_v[NC]),
        .o_ready     (w_rdy[NC]),
        .i_x         (w_x[NC]),
        .i_y         (w_y[NC]),
        .i_side      (w_s[NC]),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_x         (o_out_x),
        .o_y         (o_out_y),
        .o_heading   (o_out_heading),
        .o_saturated (o_saturated)
    );

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_out_x == MAX_C || o_out_x == MIN_C || o_out_y == MAX_C || o_out_y == MIN_C))
        else $error("saturation flag without a clipped coordinate");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input stalled while the output side is taking beats");

    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while the output register is empty");

endmodule
